// File: hdl/p1305_pkg.sv
// Shared constants and types for the Poly1305 MAC engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package p1305_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned AccW      = 130;  // accumulator, kept below 2^130 - 5
  localparam int unsigned MsgW      = 129;  // padded block, pad bit up to bit 128
  localparam int unsigned SumW      = 131;  // accumulator plus block, before multiply
  localparam int unsigned AWords    = 5;    // 32-bit words of the multiplicand
  localparam int unsigned RWords    = 4;    // 32-bit words of the clamped r
  localparam int unsigned TagW      = 128;
  localparam int unsigned CfgIndexW = 8;

  localparam logic [4:0] BlockBytes = 5'd16;

  // r clamp masks per RFC 7539
  localparam logic [63:0] RClampLow  = 64'h0ffffffc0fffffff;
  localparam logic [63:0] RClampHigh = 64'h0ffffffc0ffffffc;

  // 2^130 = 5 mod p
  localparam logic [2:0] FoldFactor = 3'd5;

  localparam logic [CfgIndexW-1:0] CfgRKeyLow  = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgRKeyHigh = 8'd1;
  localparam logic [CfgIndexW-1:0] CfgSKeyLow  = 8'd2;
  localparam logic [CfgIndexW-1:0] CfgSKeyHigh = 8'd3;

  // operands of the shared multiply-accumulate unit
  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] acc;
    logic [WordW-1:0] carry;
  } mac_in_t;

endpackage

`default_nettype wire

// File: hdl/p1305_mac32.sv
// Shared 32x32 multiply with two 32-bit addends.
// Depends on p1305_pkg for the operand struct.
`timescale 1ns / 1ps
`default_nettype none

module p1305_mac32
  import p1305_pkg::*;
(
  input  mac_in_t              op_i,
  output logic [2*WordW-1:0]   sum_o
);

  // (2^32-1)^2 + 2*(2^32-1) = 2^64 - 1, so no carry out is lost
  assign sum_o = ((2*WordW)'(op_i.a) * (2*WordW)'(op_i.b))
               + (2*WordW)'(op_i.acc) + (2*WordW)'(op_i.carry);

endmodule

`default_nettype wire

// File: hdl/p1305_pad.sv
// Message block decode: masks unused bytes and places the 0x01 pad byte.
// Depends on p1305_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module p1305_pad
  import p1305_pkg::*;
(
  input  logic [63:0]     block_low_i,
  input  logic [63:0]     block_high_i,
  input  logic [4:0]      block_bytes_i,
  output logic [MsgW-1:0] msg_o,
  output logic            empty_o
);

  logic [4:0]   n;
  logic [127:0] data;
  logic [127:0] kept;

  always_comb begin
    n    = (block_bytes_i > BlockBytes) ? BlockBytes : block_bytes_i;
    data = {block_high_i, block_low_i};
    kept = '0;
    for (int k = 0; k < 16; k++) begin
      if (5'(k) < n) begin
        kept[8*k +: 8] = data[8*k +: 8];
      end
    end
    // pad bit sits right above the last valid byte
    msg_o   = {1'b0, kept} | (MsgW'(1) << {n, 3'b000});
    empty_o = (n == 5'd0);
  end

endmodule

`default_nettype wire

// File: hdl/poly1305_mac_engine.sv
// Poly1305 MAC engine top level: key registers, sequencer and reduction datapath.
// Depends on p1305_pkg, p1305_pad and p1305_mac32.
`timescale 1ns / 1ps
`default_nettype none

// Poly1305 authenticator (RFC 7539). Write r and s over the cfg port while idle,
// then stream message blocks of up to 16 bytes; tlast marks the final block and
// one 16-byte tag follows it, after which the accumulator is clear for the next
// message. A block with data is multiplied on the single 32x32 multiply-accumulate
// unit (5 rows of 4 partial products plus one retire step each), then reduced mod
// 2^130-5 in ST_FOLD1, ST_FOLD2 and ST_FINAL before tready rises again. On a final
// block the tag is loaded in ST_TAG once the output register is free; an empty final
// block goes from ST_IDLE straight to ST_TAG.
// The tag sits in an output register, so the next block can be absorbed while
// it waits; a second tag waits until the first has been taken.
module poly1305_mac_engine
  import p1305_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: block_low[63:0], block_high[127:64], block_bytes[132:128], zero fill
  input  logic [135:0]         s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: tag_low[63:0], tag_high[127:64]
  output logic [127:0]         m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD1,
    ST_FOLD2,
    ST_FINAL,
    ST_TAG
  } state_e;

  state_e state_q, state_d;

  logic [2:0]      step_q, step_d;
  logic [2:0]      row_q, row_d;
  logic            last_q, last_d;
  logic            out_valid_q, out_valid_d;
  logic [AccW-1:0] h_q, h_d;
  logic [63:0]     r_lo_q, r_lo_d, r_hi_q, r_hi_d;
  logic [63:0]     s_lo_q, s_lo_d, s_hi_q, s_hi_d;

  logic [AWords-1:0][WordW-1:0] a_q, a_d;   // multiplicand, rotates per row
  logic [RWords-1:0][WordW-1:0] rw_q, rw_d; // clamped r, rotates per step
  logic [RWords-1:0][WordW-1:0] w_q, w_d;   // running row window
  logic [WordW-1:0]             carry_q, carry_d;
  logic [AWords-1:0][WordW-1:0] p_q, p_d;   // retired low product words
  logic [SumW-1:0]              x_q, x_d;
  logic [TagW-1:0]              tag_q, tag_d;

  logic [MsgW-1:0]      msg;
  logic                 msg_empty;
  logic [SumW-1:0]      sum;
  mac_in_t              mac_op;
  logic [2*WordW-1:0]   mac_sum;
  logic [287:0]         prod;
  logic [127:0]         prod_hi;
  logic [SumW-1:0]      g;
  logic                 in_fire;

  p1305_pad u_pad (
    .block_low_i   (s_axis_tdata[63:0]),
    .block_high_i  (s_axis_tdata[127:64]),
    .block_bytes_i (s_axis_tdata[132:128]),
    .msg_o         (msg),
    .empty_o       (msg_empty)
  );

  assign mac_op = '{a: a_q[0], b: rw_q[0], acc: w_q[0], carry: carry_q};

  p1305_mac32 u_mac (
    .op_i  (mac_op),
    .sum_o (mac_sum)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tag_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign sum     = SumW'(h_q) + SumW'(msg);
  assign prod    = {w_q, p_q};
  assign prod_hi = prod[257:130];
  assign g       = x_q + SumW'(FoldFactor);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    row_d       = row_q;
    last_d      = last_q;
    h_d         = h_q;
    r_lo_d      = r_lo_q;
    r_hi_d      = r_hi_q;
    s_lo_d      = s_lo_q;
    s_hi_d      = s_hi_q;
    a_d         = a_q;
    rw_d        = rw_q;
    w_d         = w_q;
    carry_d     = carry_q;
    p_d         = p_q;
    x_d         = x_q;
    tag_d       = tag_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRKeyLow:  r_lo_d = cfg_data_i;
        CfgRKeyHigh: r_hi_d = cfg_data_i;
        CfgSKeyLow:  s_lo_d = cfg_data_i;
        CfgSKeyHigh: s_hi_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          last_d = s_axis_tlast;
          if (msg_empty) begin
            if (s_axis_tlast) begin
              state_d = ST_TAG;
            end
          end else begin
            a_d     = (AWords*WordW)'(sum);
            rw_d    = {r_hi_q & RClampHigh, r_lo_q & RClampLow};
            w_d     = '0;
            carry_d = '0;
            step_d  = '0;
            row_d   = '0;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (step_q != 3'(RWords)) begin
          w_d     = {mac_sum[WordW-1:0], w_q[RWords-1:1]};
          carry_d = mac_sum[2*WordW-1:WordW];
          rw_d    = {rw_q[0], rw_q[RWords-1:1]};
          step_d  = step_q + 3'd1;
        end else begin
          // row done: lowest window word is final
          p_d     = {w_q[0], p_q[AWords-1:1]};
          w_d     = {carry_q, w_q[RWords-1:1]};
          carry_d = '0;
          a_d     = {a_q[0], a_q[AWords-1:1]};
          step_d  = '0;
          row_d   = row_q + 3'd1;
          if (row_q == 3'(AWords - 1)) begin
            state_d = ST_FOLD1;
          end
        end
      end
      ST_FOLD1: begin
        // hi * 2^130 = 5 * hi mod p
        x_d     = SumW'(prod[AccW-1:0]) + SumW'(prod_hi) + SumW'({prod_hi, 2'b00});
        state_d = ST_FOLD2;
      end
      ST_FOLD2: begin
        x_d     = SumW'(x_q[AccW-1:0]) + (x_q[AccW] ? SumW'(FoldFactor) : '0);
        state_d = ST_FINAL;
      end
      ST_FINAL: begin
        // x + 5 reaching 2^130 means x >= p
        h_d     = g[AccW] ? g[AccW-1:0] : x_q[AccW-1:0];
        state_d = last_q ? ST_TAG : ST_IDLE;
      end
      ST_TAG: begin
        if (!out_valid_q || m_axis_tready) begin
          tag_d       = h_q[TagW-1:0] + {s_hi_q, s_lo_q};
          out_valid_d = 1'b1;
          h_d         = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      row_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      h_q         <= '0;
      r_lo_q      <= '0;
      r_hi_q      <= '0;
      s_lo_q      <= '0;
      s_hi_q      <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      row_q       <= row_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      h_q         <= h_d;
      r_lo_q      <= r_lo_d;
      r_hi_q      <= r_hi_d;
      s_lo_q      <= s_lo_d;
      s_hi_q      <= s_hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    rw_q    <= rw_d;
    w_q     <= w_d;
    carry_q <= carry_d;
    p_q     <= p_d;
    x_q     <= x_d;
    tag_q   <= tag_d;
  end

endmodule

`default_nettype wire

// File: hdl/p1305_checker.sv
// Port-level checks for the Poly1305 MAC engine, bound to the top level.
// Depends on p1305_pkg and poly1305_mac_engine.
`timescale 1ns / 1ps
`default_nettype none

module p1305_checker
  import p1305_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic [135:0]         s_axis_tdata,
  input logic                 s_axis_tlast,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [127:0]         m_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready
);

  // a stalled tag stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("tag changed or dropped while stalled");

  // a block with data keeps the engine busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[132:128] != 5'd0)
      |=> !s_axis_tready)
    else $error("engine ready right after taking a data block");

  // empty final block with a free output register gives its tag via ST_TAG and the tag register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast
      && (s_axis_tdata[132:128] == 5'd0) && !m_axis_tvalid
      |-> ##2 m_axis_tvalid)
    else $error("tag for empty final block missing");

  // a tag is loaded only while the engine is busy closing a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("tag appeared with no final block in flight");

endmodule

bind poly1305_mac_engine p1305_checker u_checker (.*);

`default_nettype wire

// File: verif/poly1305_mac_engine_tb.sv
// Self-checking testbench for poly1305_mac_engine: streams message blocks, predicts tags.
// Depends on p1305_pkg and the poly1305_mac_engine RTL; no files or arguments needed.
`timescale 1ns / 1ps

module poly1305_mac_engine_tb;
  import p1305_pkg::*;

  localparam int unsigned SettleCycles = 40;   // longer than one absorb plus its tag
  localparam int unsigned BlockTarget  = 1650;
  localparam logic [258:0] PolyPrime   = (259'd1 << 130) - 259'd5;
  localparam logic [63:0]  AllOnes     = '1;

  // RFC 7539 section 2.5.2 key and message, little-endian words
  localparam logic [63:0] RfcRLow  = 64'h336d555778bed685;
  localparam logic [63:0] RfcRHigh = 64'ha806d542fe52447f;
  localparam logic [63:0] RfcSLow  = 64'hfdb20dfb8a800301;
  localparam logic [63:0] RfcSHigh = 64'h1bf54941aff6bf4a;

  typedef enum logic {ROW_KEYS, ROW_BLOCK} row_kind_e;

  // ROW_KEYS: w0..w3 = r low, r high, s low, s high; ROW_BLOCK: w0/w1 = block low/high
  typedef struct {
    row_kind_e    kind;
    logic [63:0]  w0;
    logic [63:0]  w1;
    logic [63:0]  w2;
    logic [63:0]  w3;
    logic [4:0]   nbytes;
    logic         last;
    logic         known;
    logic [127:0] tag;
  } vec_row_t;

  logic clk_i;
  logic rst_ni;

  logic [135:0]         s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [127:0]         m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [63:0]          cfg_data_i;

  // predictor state
  logic [63:0]  key_rl, key_rh, key_sl, key_sh;
  logic [129:0] poly_acc;
  logic [127:0] expected_tags[$];

  int unsigned err_count;
  int unsigned blocks_sent;
  int unsigned burst_left;

  int unsigned rx_left  = 0;
  int unsigned rx_cycle = 0;

  vec_row_t dir_tbl [0:24] = '{
    // reset keys are zero: every tag is zero
    '{ROW_BLOCK, '0, '0, '0, '0, 5'd0, 1'b1, 1'b1, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd16, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd16, 1'b1, 1'b1, '0},
    // published vector: "Cryptographic Forum Research Group"
    '{ROW_KEYS, RfcRLow, RfcRHigh, RfcSLow, RfcSHigh, 5'd0, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, 64'h72676f7470797243, 64'h6f46206369687061, '0, '0, 5'd16, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, 64'h65736552206d7572, 64'h6f72472068637261, '0, '0, 5'd16, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, 64'h0000000000007075, '0, '0, '0, 5'd2, 1'b1, 1'b1,
      128'ha927010caf8b2bc2_c6365130c11d06a8},
    // empty message gives s
    '{ROW_BLOCK, '0, '0, '0, '0, 5'd0, 1'b1, 1'b1, {RfcSHigh, RfcSLow}},
    // widest clamp, s at max; partial blocks at every byte boundary class
    '{ROW_KEYS, AllOnes, AllOnes, AllOnes, AllOnes, 5'd0, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd0, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd16, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd15, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd8, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd7, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd1, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd0, 1'b1, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd31, 1'b1, 1'b0, '0},
    '{ROW_BLOCK, '0, '0, '0, '0, 5'd17, 1'b1, 1'b0, '0},
    // r = 1, s = 0: tag is the padded block mod p
    '{ROW_KEYS, 64'd1, '0, '0, '0, 5'd0, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd16, 1'b1, 1'b1, {AllOnes, AllOnes}},
    '{ROW_BLOCK, '0, '0, '0, '0, 5'd16, 1'b1, 1'b1, '0},
    // 2 * (2^129 - 1) = 2^130 - 2, reduces to 3
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd16, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd16, 1'b1, 1'b1, 128'd3},
    // r = 1, s at max: adding s wraps mod 2^128
    '{ROW_KEYS, 64'd1, '0, AllOnes, AllOnes, 5'd0, 1'b0, 1'b0, '0},
    '{ROW_BLOCK, AllOnes, AllOnes, '0, '0, 5'd1, 1'b1, 1'b1, 128'h1fe}
  };

  poly1305_mac_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // (acc + padded block) * clamped r mod 2^130 - 5
  function automatic logic [129:0] poly_mulmod(input logic [129:0] acc,
                                               input logic [127:0] data,
                                               input int unsigned nbytes,
                                               input logic [127:0] r_clamped);
    logic [258:0] msg;
    logic [258:0] sum;
    logic [258:0] prod;
    msg  = ({131'd0, data} & ((259'd1 << (8 * nbytes)) - 259'd1)) | (259'd1 << (8 * nbytes));
    sum  = {129'd0, acc} + msg;
    prod = (sum * {131'd0, r_clamped}) % PolyPrime;
    return prod[129:0];
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return AllOnes;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] exp);
    $display("%0t: %s mismatch: got %h, expected %h", $time, field, got, exp);
    err_count++;
  endtask

  // Presents one block, holds it until the transaction, then updates the predictor.
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] nbytes, input logic last,
                            input logic known, input logic [127:0] known_tag);
    int unsigned gap;
    int unsigned n;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap = $urandom_range(1, 40);
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, nbytes, hi, lo};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);

    n = (nbytes > 5'd16) ? 16 : nbytes;
    if (n != 0)
      poly_acc = poly_mulmod(poly_acc, {hi, lo}, n,
                             {key_rh & RClampHigh, key_rl & RClampLow});
    if (last) begin
      if (known)
        expected_tags.push_back(known_tag);
      else
        expected_tags.push_back(poly_acc[127:0] + {key_sh, key_sl});
      poly_acc = '0;
    end
    blocks_sent++;
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgRKeyLow:  key_rl = val;
      CfgRKeyHigh: key_rh = val;
      CfgSKeyLow:  key_sl = val;
      CfgSKeyHigh: key_sh = val;
      default:     ;
    endcase
  endtask

  // Keys change only with the engine idle: all tags out, last absorb finished.
  task automatic apply_keys(input logic [63:0] rl, input logic [63:0] rh,
                            input logic [63:0] sl, input logic [63:0] sh);
    s_axis_tvalid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(CfgRKeyLow, rl);
    write_reg(CfgRKeyHigh, rh);
    write_reg(CfgSKeyLow, sl);
    write_reg(CfgSKeyHigh, sh);
    cfg_valid_i <= 1'b0;
  endtask

  // One message split into 16-byte blocks; some stray empty blocks, oversized
  // counts and a trailing empty final block mixed in.
  task automatic send_message();
    int unsigned len;
    int unsigned nblk;
    int unsigned rem;
    logic        trail_empty;
    logic [4:0]  nb;
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = $urandom_range(65, 200);
      default: len = $urandom_range(1, 64);
    endcase
    nblk = (len + 15) / 16;
    rem  = len % 16;
    trail_empty = (len != 0) && ($urandom_range(0, 5) == 0);
    for (int unsigned k = 0; k < nblk; k++) begin
      if ($urandom_range(0, 15) == 0)
        send_block(rand_word(), rand_word(), 5'd0, 1'b0, 1'b0, '0);
      if (k == nblk - 1 && rem != 0)
        nb = 5'(rem);
      else if ($urandom_range(0, 9) == 0)
        nb = 5'($urandom_range(17, 31));
      else
        nb = 5'd16;
      send_block(rand_word(), rand_word(), nb, (k == nblk - 1) && !trail_empty, 1'b0, '0);
    end
    if (nblk == 0 || trail_empty)
      send_block(rand_word(), rand_word(), 5'd0, 1'b1, 1'b0, '0);
  endtask

  // Receiver: long ready stretches, fast toggling, and long stalls.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      case (rx_cycle[9:8])
        2'd0: begin
          m_axis_tready <= 1'b1;
          rx_left       <= 64;
        end
        2'd1, 2'd2: begin
          m_axis_tready <= ~m_axis_tready;
          rx_left       <= $urandom_range(0, 3);
        end
        default: begin
          m_axis_tready <= ~m_axis_tready;
          rx_left       <= m_axis_tready ? $urandom_range(5, 60) : $urandom_range(0, 8);
        end
      endcase
    end
  end

  // Tag checker
  always @(posedge clk_i) begin
    logic [127:0] exp_tag;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_tags.size() == 0) begin
        $display("%0t: tag %h with no message pending", $time, m_axis_tdata);
        err_count++;
      end else begin
        exp_tag = expected_tags.pop_front();
        if (m_axis_tdata[63:0] !== exp_tag[63:0])
          flag_mismatch("tag_low", m_axis_tdata[63:0], exp_tag[63:0]);
        if (m_axis_tdata[127:64] !== exp_tag[127:64])
          flag_mismatch("tag_high", m_axis_tdata[127:64], exp_tag[127:64]);
      end
    end
  end

  initial begin
    int unsigned msgs_left;
    logic [63:0] rl, rh, sl, sh;
    err_count     = 0;
    blocks_sent   = 0;
    burst_left    = 0;
    msgs_left     = 0;
    key_rl        = '0;
    key_rh        = '0;
    key_sl        = '0;
    key_sh        = '0;
    poly_acc      = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgRKeyLow;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_KEYS)
        apply_keys(dir_tbl[i].w0, dir_tbl[i].w1, dir_tbl[i].w2, dir_tbl[i].w3);
      else
        send_block(dir_tbl[i].w0, dir_tbl[i].w1, dir_tbl[i].nbytes, dir_tbl[i].last,
                   dir_tbl[i].known, dir_tbl[i].tag);
    end

    while (blocks_sent < BlockTarget) begin
      if (msgs_left == 0) begin
        rl = rand_word();
        rh = rand_word();
        sl = rand_word();
        sh = rand_word();
        if ($urandom_range(0, 5) == 0) begin
          rl = 64'd1;
          rh = '0;
        end
        apply_keys(rl, rh, sl, sh);
        msgs_left = $urandom_range(20, 80);
      end
      send_message();
      msgs_left--;
    end

    s_axis_tvalid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0)
      $display("poly1305_mac_engine_tb: done, clean");
    else
      $display("poly1305_mac_engine_tb: done, errors");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("poly1305_mac_engine_tb: done, errors");
    $finish;
  end

endmodule
